// ===== rtl/edcs_pkg.sv =====
package edcs_pkg;

    // Default widths of the pulse counter and of the interval field.
    localparam int COUNT_WIDTH_DEF    = 32;
    localparam int INTERVAL_WIDTH_DEF = 24;

    // Fixed field widths.
    localparam int PPR_WIDTH       = 16;
    localparam int OUT_WIDTH       = 32;
    localparam int FRAC_BITS       = 16;
    localparam int CFG_INDEX_WIDTH = 8;
    localparam int CFG_DATA_WIDTH  = 16;

    // Register indices on the configuration channel.
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_PULSES_PER_ROUND = 8'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_INVERT_DIRECTION = 8'd1;

    localparam logic [PPR_WIDTH-1:0] PPR_RESET = 16'd1024;

    // 2*pi in Q32 times one million, so that the interval may be given in microseconds.
    localparam int                          SPEED_NUM_WIDTH = 55;
    localparam logic [SPEED_NUM_WIDTH-1:0] SPEED_NUM        = 55'd26986075409000000;

endpackage

// ===== rtl/encoder_direction_count_speed.sv =====
// Encoder tracker for one motor: direction, saturating pulse count and speed.
// Input channel (i_in_valid / o_in_stall): an encoder event (req_type 0)
// samples lines A and B, and a rising edge of A takes the direction from B.
// Each event then counts one pulse up or down. A speed request (req_type 1)
// with nonzero interval and pulses-per-round values turns the count into a
// signed Q16.16 speed in rad/s, saturated, and clears the count.
// Output channel (o_out_valid / i_out_stall): one result per request, carrying
// the stored speed, the count, the direction and a flag for a new speed.
// An encoder event, or a speed request that changes nothing, goes straight
// to the result stage, and the next request is taken only once that result
// has been loaded into the output register. A speed request with work to do
// runs a shift-and-add multiplier, a rounding step, a restoring divider
// (multiplier and divider both one bit per cycle), a saturation step and the
// result stage. One request is in progress at a time.
// The input is taken whenever the block is idle, even while the previous result
// still waits in the output register; a stalled receiver holds the result
// steady and the block waits with the next one until the register frees.
// Reset clears the count and the speed, sets the direction to forward and loads
// the register defaults (1024 pulses per round, no inversion). Configuration
// writes are always taken and must only be made while the block is idle.
module encoder_direction_count_speed #(
    parameter int COUNT_WIDTH    = edcs_pkg::COUNT_WIDTH_DEF,
    parameter int INTERVAL_WIDTH = edcs_pkg::INTERVAL_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Configuration channel
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [edcs_pkg::CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [edcs_pkg::CFG_DATA_WIDTH-1:0]  i_cfg_data,
    // Input channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic                                 i_req_type,
    input  logic                                 i_line_a,
    input  logic                                 i_line_b,
    input  logic [INTERVAL_WIDTH-1:0]            i_interval_us,
    // Output channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [edcs_pkg::OUT_WIDTH-1:0] o_speed_rad_s,
    output logic signed [edcs_pkg::OUT_WIDTH-1:0] o_pulse_count,
    output logic                                 o_is_forward,
    output logic                                 o_speed_updated
);

    localparam int MUL_STEPS = (COUNT_WIDTH > INTERVAL_WIDTH) ? COUNT_WIDTH : INTERVAL_WIDTH;
    localparam int DACC_W    = edcs_pkg::PPR_WIDTH + INTERVAL_WIDTH;
    localparam int DEN_W     = DACC_W + edcs_pkg::FRAC_BITS;
    localparam int PROD_W    = COUNT_WIDTH + edcs_pkg::SPEED_NUM_WIDTH;
    localparam int NUM_W     = ((PROD_W > DEN_W - 1) ? PROD_W : DEN_W - 1) + 1;
    localparam int STEPS_MAX = (NUM_W > MUL_STEPS) ? NUM_W : MUL_STEPS;
    localparam int CNT_W     = $clog2(STEPS_MAX + 1);
    localparam int QUO_W     = edcs_pkg::OUT_WIDTH + 1;
    localparam int OW        = edcs_pkg::OUT_WIDTH;

    localparam logic signed [COUNT_WIDTH-1:0] CMAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
    localparam logic signed [COUNT_WIDTH-1:0] CMIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};
    localparam logic [QUO_W-1:0] LIMIT_POS = {2'b00, {(OW-1){1'b1}}};
    localparam logic [QUO_W-1:0] LIMIT_NEG = {2'b01, {(OW-1){1'b0}}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ADD,
        S_DIV,
        S_SPD,
        S_FIN
    } t_state;

    t_state r_state;

    // Architectural state
    logic [edcs_pkg::PPR_WIDTH-1:0] r_ppr;
    logic                           r_invert;
    logic                           r_last_a;
    logic                           r_dir;
    logic signed [COUNT_WIDTH-1:0]  r_count;
    logic signed [OW-1:0]           r_speed;
    logic                           r_updated;

    // Serial datapath
    logic [MUL_STEPS-1:0] r_mag;
    logic [MUL_STEPS-1:0] r_tim;
    logic [NUM_W-1:0]     r_acc;
    logic [DACC_W-1:0]    r_dacc;
    logic [DEN_W-1:0]     r_rem;
    logic [QUO_W-1:0]     r_quo;
    logic                 r_big;
    logic                 r_neg;
    logic [CNT_W-1:0]     r_step;

    // Output register
    logic                 r_out_valid;
    logic signed [OW-1:0] r_out_speed;
    logic signed [OW-1:0] r_out_count;
    logic                 r_out_forward;
    logic                 r_out_updated;

    logic                          w_in_accept;
    logic                          n_dir;
    logic signed [COUNT_WIDTH-1:0] n_count;
    logic [COUNT_WIDTH-1:0]        w_abs;
    logic [DEN_W-1:0]              w_den;
    logic [DEN_W:0]                w_trial;
    logic                          w_ge;
    logic [QUO_W-1:0]              w_limit;
    logic [QUO_W-1:0]              w_sat;

    assign o_cfg_ready     = 1'b1;
    assign o_in_stall      = (r_state != S_IDLE);
    assign w_in_accept     = i_in_valid && (r_state == S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_speed_rad_s   = r_out_speed;
    assign o_pulse_count   = r_out_count;
    assign o_is_forward    = r_out_forward;
    assign o_speed_updated = r_out_updated;

    always_comb begin
        // The direction is taken from B only on a rising edge of A.
        n_dir = (!r_last_a && i_line_a) ? (i_line_b ^ r_invert) : r_dir;
        n_count = r_count;
        if (n_dir) begin
            if (r_count != CMAX) begin
                n_count = r_count + COUNT_WIDTH'(1);
            end
        end else begin
            if (r_count != CMIN) begin
                n_count = r_count - COUNT_WIDTH'(1);
            end
        end

        w_abs   = r_count[COUNT_WIDTH-1] ? (~r_count + COUNT_WIDTH'(1)) : r_count;
        w_den   = {r_dacc, {edcs_pkg::FRAC_BITS{1'b0}}};
        w_trial = {r_rem, r_acc[NUM_W-1]};
        w_ge    = (w_trial >= {1'b0, w_den});

        w_limit = r_neg ? LIMIT_NEG : LIMIT_POS;
        w_sat   = (r_big || (r_quo > w_limit)) ? w_limit : r_quo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_ppr         <= edcs_pkg::PPR_RESET;
            r_invert      <= 1'b0;
            r_last_a      <= 1'b0;
            r_dir         <= 1'b1;
            r_count       <= '0;
            r_speed       <= '0;
            r_updated     <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    edcs_pkg::REG_PULSES_PER_ROUND: begin
                        r_ppr <= i_cfg_data[edcs_pkg::PPR_WIDTH-1:0];
                    end
                    edcs_pkg::REG_INVERT_DIRECTION: begin
                        r_invert <= i_cfg_data[0];
                    end
                    default: begin
                    end
                endcase
            end

            // In S_FIN the output register is refilled in the same cycle instead.
            if (r_out_valid && !i_out_stall && (r_state != S_FIN)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_accept) begin
                        r_updated <= 1'b0;
                        if (!i_req_type) begin
                            r_dir    <= n_dir;
                            r_last_a <= i_line_a;
                            r_count  <= n_count;
                            r_state  <= S_FIN;
                        end else if ((i_interval_us != '0) && (r_ppr != '0)) begin
                            r_neg   <= r_count[COUNT_WIDTH-1];
                            r_mag   <= MUL_STEPS'(w_abs);
                            r_tim   <= MUL_STEPS'(i_interval_us);
                            r_acc   <= '0;
                            r_dacc  <= '0;
                            r_step  <= CNT_W'(MUL_STEPS);
                            r_state <= S_MUL;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_MUL: begin
                    // Both products are formed most significant bit first.
                    r_acc  <= {r_acc[NUM_W-2:0], 1'b0}
                              + (r_mag[MUL_STEPS-1] ? NUM_W'(edcs_pkg::SPEED_NUM) : '0);
                    r_dacc <= {r_dacc[DACC_W-2:0], 1'b0}
                              + (r_tim[MUL_STEPS-1] ? DACC_W'(r_ppr) : '0);
                    r_mag  <= {r_mag[MUL_STEPS-2:0], 1'b0};
                    r_tim  <= {r_tim[MUL_STEPS-2:0], 1'b0};
                    r_step <= r_step - CNT_W'(1);
                    if (r_step == CNT_W'(1)) begin
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    // Adding half the divisor rounds the quotient half away from zero.
                    r_acc   <= r_acc + NUM_W'({r_dacc, {(edcs_pkg::FRAC_BITS-1){1'b0}}});
                    r_rem   <= '0;
                    r_quo   <= '0;
                    r_big   <= 1'b0;
                    r_step  <= CNT_W'(NUM_W);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem  <= w_ge ? DEN_W'(w_trial - {1'b0, w_den}) : w_trial[DEN_W-1:0];
                    r_quo  <= {r_quo[QUO_W-2:0], w_ge};
                    r_big  <= r_big | r_quo[QUO_W-1];
                    r_acc  <= {r_acc[NUM_W-2:0], 1'b0};
                    r_step <= r_step - CNT_W'(1);
                    if (r_step == CNT_W'(1)) begin
                        r_state <= S_SPD;
                    end
                end
                S_SPD: begin
                    r_speed   <= r_neg ? -$signed(w_sat[OW-1:0]) : $signed(w_sat[OW-1:0]);
                    r_count   <= '0;
                    r_updated <= 1'b1;
                    r_state   <= S_FIN;
                end
                S_FIN: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid   <= 1'b1;
                        r_out_speed   <= r_speed;
                        r_out_count   <= OW'(r_count);
                        r_out_forward <= r_dir;
                        r_out_updated <= r_updated;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
